// ----- rtl/lmsd_pkg.sv -----
// Shared types and constants for the LED matrix scan driver.
// Request and result codes, register indexes, the gamma table and the mode struct.
// No dependencies.
`default_nettype none

package lmsd_pkg;

  typedef enum logic [2:0] {
    REQ_WRITE = 3'd0,
    REQ_READ  = 3'd1,
    REQ_FILL  = 3'd2,
    REQ_SWAP  = 3'd3,
    REQ_COPY  = 3'd4,
    REQ_TICK  = 3'd5
  } req_type_e;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_SHIFT  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  localparam int unsigned PaddrW = 4;
  localparam int unsigned PdataW = 32;

  localparam logic [1:0] RegBrightness = 2'd0;
  localparam logic [1:0] RegMinLevel   = 2'd1;
  localparam logic [1:0] RegMaxLevel   = 2'd2;

  localparam logic [7:0] BrightnessRst = 8'd128;
  localparam logic [7:0] MinLevelRst   = 8'd0;
  localparam logic [7:0] MaxLevelRst   = 8'd255;

  // Panel mode seen by the scan logic, plus the effect of a register write.
  typedef struct packed {
    logic       stopped;
    logic       dimming;
    logic [7:0] level;
    logic       set_on;
    logic       set_off;
  } mode_t;

  localparam logic [7:0] GammaLut [256] = '{
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd2,
    8'd2,   8'd2,   8'd2,   8'd2,   8'd3,   8'd3,   8'd3,   8'd3,
    8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,   8'd6,
    8'd6,   8'd6,   8'd7,   8'd7,   8'd8,   8'd8,   8'd8,   8'd9,
    8'd9,   8'd10,  8'd10,  8'd10,  8'd11,  8'd11,  8'd12,  8'd12,
    8'd13,  8'd13,  8'd14,  8'd14,  8'd15,  8'd15,  8'd16,  8'd16,
    8'd17,  8'd17,  8'd18,  8'd18,  8'd19,  8'd19,  8'd20,  8'd21,
    8'd21,  8'd22,  8'd22,  8'd23,  8'd24,  8'd24,  8'd25,  8'd26,
    8'd26,  8'd27,  8'd28,  8'd28,  8'd29,  8'd30,  8'd30,  8'd31,
    8'd32,  8'd32,  8'd33,  8'd34,  8'd35,  8'd35,  8'd36,  8'd37,
    8'd38,  8'd38,  8'd39,  8'd40,  8'd41,  8'd41,  8'd42,  8'd43,
    8'd44,  8'd45,  8'd46,  8'd46,  8'd47,  8'd48,  8'd49,  8'd50,
    8'd51,  8'd52,  8'd53,  8'd53,  8'd54,  8'd55,  8'd56,  8'd57,
    8'd58,  8'd59,  8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd65,
    8'd66,  8'd67,  8'd68,  8'd69,  8'd70,  8'd71,  8'd72,  8'd73,
    8'd74,  8'd75,  8'd76,  8'd77,  8'd78,  8'd79,  8'd80,  8'd81,
    8'd82,  8'd83,  8'd84,  8'd86,  8'd87,  8'd88,  8'd89,  8'd90,
    8'd91,  8'd92,  8'd93,  8'd95,  8'd96,  8'd97,  8'd98,  8'd99,
    8'd100, 8'd102, 8'd103, 8'd104, 8'd105, 8'd107, 8'd108, 8'd109,
    8'd110, 8'd111, 8'd113, 8'd114, 8'd115, 8'd116, 8'd118, 8'd119,
    8'd120, 8'd122, 8'd123, 8'd124, 8'd126, 8'd127, 8'd128, 8'd129,
    8'd131, 8'd132, 8'd134, 8'd135, 8'd136, 8'd138, 8'd139, 8'd140,
    8'd142, 8'd143, 8'd145, 8'd146, 8'd147, 8'd149, 8'd150, 8'd152,
    8'd153, 8'd154, 8'd156, 8'd157, 8'd159, 8'd160, 8'd162, 8'd163,
    8'd165, 8'd166, 8'd168, 8'd169, 8'd171, 8'd172, 8'd174, 8'd175,
    8'd177, 8'd178, 8'd180, 8'd181, 8'd183, 8'd184, 8'd186, 8'd188,
    8'd189, 8'd191, 8'd192, 8'd194, 8'd195, 8'd197, 8'd199, 8'd200,
    8'd202, 8'd204, 8'd205, 8'd207, 8'd208, 8'd210, 8'd212, 8'd213,
    8'd215, 8'd217, 8'd218, 8'd220, 8'd222, 8'd224, 8'd225, 8'd227,
    8'd229, 8'd230, 8'd232, 8'd234, 8'd236, 8'd237, 8'd239, 8'd241,
    8'd243, 8'd244, 8'd246, 8'd248, 8'd250, 8'd251, 8'd253, 8'd255
  };

endpackage

`default_nettype wire

// ----- rtl/lmsd_in_if.sv -----
// Request channel of the LED matrix scan driver: valid/ready plus one request item.
// No dependencies.
`default_nettype none

interface lmsd_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [3:0] row;
  logic [4:0] col;
  logic [2:0] rgb;

  modport source (output valid, output req_type, output row, output col, output rgb,
                  input ready);
  modport sink   (input valid, input req_type, input row, input col, input rgb,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/lmsd_out_if.sv -----
// Result channel of the LED matrix scan driver: valid/ready plus one result item.
// No dependencies.
`default_nettype none

interface lmsd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [5:0] rgb_data;
  logic [2:0] row_select;
  logic       latch;
  logic       output_enable;
  logic       last;

  modport source (output valid, output kind, output rgb_data, output row_select,
                  output latch, output output_enable, output last, input ready);
  modport sink   (input valid, input kind, input rgb_data, input row_select,
                  input latch, input output_enable, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/led_matrix_scan_driver_top.sv -----
// Top level of the LED matrix scan driver: frame store, scan sequencer, result register.
// Depends on lmsd_pkg, lmsd_in_if, lmsd_out_if and lmsd_apb_regs.
`default_nettype none

// The block keeps two frame buffers of SECTIONS x COLUMNS six-bit words in one
// single-port-write, registered-read memory; each word holds the lower-half pixel in
// bits 2..0 and the upper-half pixel in bits 5..3. After reset a clearing pass writes
// zero to all 2 * 2**clog2(SECTIONS) * 2**clog2(COLUMNS) words while req_i.ready
// stays low; APB writes are taken during that pass.
// One request item is worked on at a time, and req_i.ready is high in the idle state
// even when a result still waits in the output register. Fill and copy go through
// the buffer one word per cycle; a tick that wraps the PWM counter while the mode is
// not stopped streams one section, one column per cycle when the result side keeps
// ready high.

module led_matrix_scan_driver_top #(
  parameter int unsigned SECTIONS = 8,
  parameter int unsigned COLUMNS  = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  lmsd_in_if.sink                         req_i,
  lmsd_out_if.source                      rsp_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lmsd_pkg::PaddrW-1:0] paddr,
  input  wire logic [lmsd_pkg::PdataW-1:0] pwdata,
  output logic      [lmsd_pkg::PdataW-1:0] prdata,
  output logic                             pready
);

  localparam int unsigned SecW   = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int unsigned ColW   = $clog2(COLUMNS);
  localparam int unsigned PlaneW = SecW + ColW;
  localparam int unsigned AddrW  = PlaneW + 1;
  localparam int unsigned Depth  = 2 ** AddrW;

  typedef enum logic [8:0] {
    ST_CLEAR    = 9'b000000001,
    ST_IDLE     = 9'b000000010,
    ST_PIX_WR   = 9'b000000100,
    ST_READ_OUT = 9'b000001000,
    ST_STATUS   = 9'b000010000,
    ST_SHIFT    = 9'b000100000,
    ST_FILL     = 9'b001000000,
    ST_COPY     = 9'b010000000,
    ST_COPY_END = 9'b100000000
  } state_e;

  // Section of a pixel row: rows at or above SECTIONS fold onto the upper half.
  function automatic logic [SecW-1:0] section_of(input logic [3:0] row);
    logic [4:0] v;
    v = {1'b0, row};
    for (int i = 0; i < 8; i++) begin
      if (v >= 5'(SECTIONS)) begin
        v = v - 5'(SECTIONS);
      end
    end
    return SecW'(v);
  endfunction

  lmsd_pkg::mode_t mode;

  lmsd_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode_o  (mode)
  );

  // Sequencer state
  state_e            state_q, state_d;
  logic              front_q, front_d;
  logic [SecW-1:0]   sec_q, sec_d;
  logic [7:0]        cnt_q, cnt_d;
  logic              panel_on_q, panel_on_d;
  logic              old_on_q, old_on_d;
  logic [ColW-1:0]   col_q, col_d;
  logic [AddrW-1:0]  sweep_q, sweep_d;
  logic              cp_valid_q, cp_valid_d;
  logic [PlaneW-1:0] cp_addr_q, cp_addr_d;
  logic [AddrW-1:0]  pix_addr_q, pix_addr_d;
  logic              upper_q, upper_d;
  logic              in_range_q, in_range_d;
  logic [2:0]        rgb_q, rgb_d;

  // Frame store
  logic [5:0]        store_q [Depth];
  logic [5:0]        rdata_q;
  logic              rd_en;
  logic [AddrW-1:0]  raddr;
  logic              we;
  logic [AddrW-1:0]  waddr;
  logic [5:0]        wdata;

  // Result register
  logic              out_valid_q;
  logic [1:0]        out_kind_q, out_kind_d;
  logic [5:0]        out_data_q, out_data_d;
  logic [2:0]        out_rsel_q, out_rsel_d;
  logic              out_latch_q, out_latch_d;
  logic              out_oe_q, out_oe_d;
  logic              out_last_q, out_last_d;
  logic              out_load;
  logic              out_free;

  // Decoded request
  logic              accept;
  logic [SecW-1:0]   in_sec;
  logic              in_upper;
  logic              in_range;
  logic [ColW-1:0]   in_col;
  logic [AddrW-1:0]  in_addr;
  logic [7:0]        cnt_inc;
  logic              wrap;
  logic              hit_now;
  logic              hit_zero;
  logic              col_last;
  logic [ColW-1:0]   col_next;
  logic [2:0]        pixel;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign in_sec   = section_of(req_i.row);
  assign in_upper = {1'b0, req_i.row} >= 5'(SECTIONS);
  assign in_range = {2'b00, req_i.col} < 7'(COLUMNS);
  assign in_col   = ColW'(req_i.col);
  assign in_addr  = {~front_q, in_sec, in_col};

  // PWM compare against the gamma level of the brightness register
  assign cnt_inc  = cnt_q + 8'd1;
  assign wrap     = (cnt_inc == 8'd0);
  assign hit_now  = mode.dimming && (mode.level == cnt_inc);
  assign hit_zero = mode.dimming && (mode.level == 8'd0);

  assign col_last = (col_q == ColW'(COLUMNS - 1));
  assign col_next = col_q + ColW'(1);
  assign pixel    = !in_range_q ? 3'd0 : (upper_q ? rdata_q[5:3] : rdata_q[2:0]);

  always_comb begin
    state_d    = state_q;
    front_d    = front_q;
    sec_d      = sec_q;
    cnt_d      = cnt_q;
    panel_on_d = panel_on_q;
    old_on_d   = old_on_q;
    col_d      = col_q;
    sweep_d    = sweep_q;
    cp_valid_d = (state_q == ST_COPY);
    cp_addr_d  = cp_addr_q;
    pix_addr_d = pix_addr_q;
    upper_d    = upper_q;
    in_range_d = in_range_q;
    rgb_d      = rgb_q;

    rd_en = 1'b0;
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;

    out_load    = 1'b0;
    out_kind_d  = out_kind_q;
    out_data_d  = out_data_q;
    out_rsel_d  = out_rsel_q;
    out_latch_d = out_latch_q;
    out_oe_d    = out_oe_q;
    out_last_d  = out_last_q;

    // A register write forces the panel on or off in the full-on and stopped modes.
    if (mode.set_on) begin
      panel_on_d = 1'b1;
    end else if (mode.set_off) begin
      panel_on_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        we      = 1'b1;
        waddr   = sweep_q;
        wdata   = '0;
        sweep_d = sweep_q + AddrW'(1);
        if (sweep_q == '1) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          unique case (req_i.req_type)
            lmsd_pkg::REQ_WRITE, lmsd_pkg::REQ_READ: begin
              // Fetch the word now; merge it in the next cycle, or select it in the read-out state.
              rd_en      = 1'b1;
              raddr      = in_addr;
              pix_addr_d = in_addr;
              upper_d    = in_upper;
              in_range_d = in_range;
              rgb_d      = req_i.rgb;
              state_d    = (req_i.req_type == lmsd_pkg::REQ_WRITE) ? ST_PIX_WR : ST_READ_OUT;
            end
            lmsd_pkg::REQ_FILL: begin
              rgb_d   = req_i.rgb;
              sweep_d = '0;
              state_d = ST_FILL;
            end
            lmsd_pkg::REQ_SWAP: begin
              front_d = ~front_q;
            end
            lmsd_pkg::REQ_COPY: begin
              sweep_d = '0;
              state_d = ST_COPY;
            end
            lmsd_pkg::REQ_TICK: begin
              cnt_d = cnt_inc;
              if (wrap && !mode.stopped) begin
                // Refresh one section; the last column carries the new enable.
                old_on_d   = panel_on_q;
                panel_on_d = !hit_zero;
                col_d      = '0;
                rd_en      = 1'b1;
                raddr      = {front_q, sec_q, {ColW{1'b0}}};
                state_d    = ST_SHIFT;
              end else begin
                if (hit_now) begin
                  panel_on_d = 1'b0;
                end
                state_d = ST_STATUS;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_PIX_WR: begin
        if (in_range_q) begin
          we    = 1'b1;
          waddr = pix_addr_q;
          wdata = upper_q ? {rgb_q, rdata_q[2:0]} : {rdata_q[5:3], rgb_q};
        end
        state_d = ST_IDLE;
      end

      ST_READ_OUT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_kind_d  = lmsd_pkg::KIND_READ;
          out_data_d  = {3'd0, pixel};
          out_rsel_d  = 3'd0;
          out_latch_d = 1'b0;
          out_oe_d    = panel_on_q;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      ST_STATUS: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_kind_d  = lmsd_pkg::KIND_STATUS;
          out_data_d  = 6'd0;
          out_rsel_d  = 3'd0;
          out_latch_d = 1'b0;
          out_oe_d    = panel_on_q;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      ST_SHIFT: begin
        // rdata_q holds column col_q; advance only when the result register frees.
        if (out_free) begin
          out_load    = 1'b1;
          out_kind_d  = lmsd_pkg::KIND_SHIFT;
          out_data_d  = rdata_q;
          out_rsel_d  = 3'(sec_q);
          out_latch_d = col_last;
          out_oe_d    = col_last ? panel_on_q : old_on_q;
          out_last_d  = col_last;
          if (col_last) begin
            sec_d   = (sec_q == SecW'(SECTIONS - 1)) ? '0 : sec_q + SecW'(1);
            state_d = ST_IDLE;
          end else begin
            col_d = col_next;
            rd_en = 1'b1;
            raddr = {front_q, sec_q, col_next};
          end
        end
      end

      ST_FILL: begin
        we      = 1'b1;
        waddr   = {~front_q, sweep_q[PlaneW-1:0]};
        wdata   = {rgb_q, rgb_q};
        sweep_d = sweep_q + AddrW'(1);
        if (sweep_q[PlaneW-1:0] == '1) begin
          state_d = ST_IDLE;
        end
      end

      ST_COPY: begin
        // Read front word i while writing back word i-1.
        rd_en     = 1'b1;
        raddr     = {front_q, sweep_q[PlaneW-1:0]};
        cp_addr_d = sweep_q[PlaneW-1:0];
        if (cp_valid_q) begin
          we    = 1'b1;
          waddr = {~front_q, cp_addr_q};
          wdata = rdata_q;
        end
        sweep_d = sweep_q + AddrW'(1);
        if (sweep_q[PlaneW-1:0] == '1) begin
          state_d = ST_COPY_END;
        end
      end

      ST_COPY_END: begin
        we      = 1'b1;
        waddr   = {~front_q, cp_addr_q};
        wdata   = rdata_q;
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      front_q    <= 1'b0;
      sec_q      <= '0;
      cnt_q      <= 8'd0;
      panel_on_q <= 1'b0;
      old_on_q   <= 1'b0;
      col_q      <= '0;
      sweep_q    <= '0;
      cp_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      front_q    <= front_d;
      sec_q      <= sec_d;
      cnt_q      <= cnt_d;
      panel_on_q <= panel_on_d;
      old_on_q   <= old_on_d;
      col_q      <= col_d;
      sweep_q    <= sweep_d;
      cp_valid_q <= cp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_addr_q  <= cp_addr_d;
    pix_addr_q <= pix_addr_d;
    upper_q    <= upper_d;
    in_range_q <= in_range_d;
    rgb_q      <= rgb_d;
  end

  // Frame store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= store_q[raddr];
    end
  end

  // Result register: load when empty or being drained, drop when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q  <= out_kind_d;
    out_data_q  <= out_data_d;
    out_rsel_q  <= out_rsel_d;
    out_latch_q <= out_latch_d;
    out_oe_q    <= out_oe_d;
    out_last_q  <= out_last_d;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.kind          = out_kind_q;
  assign rsp_o.rgb_data      = out_data_q;
  assign rsp_o.row_select    = out_rsel_q;
  assign rsp_o.latch         = out_latch_q;
  assign rsp_o.output_enable = out_oe_q;
  assign rsp_o.last          = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/lmsd_apb_regs.sv -----
// APB register file of the LED matrix scan driver: brightness, min and max level.
// Derives the panel mode and gamma compare level. Depends on lmsd_pkg.
`default_nettype none

module lmsd_apb_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lmsd_pkg::PaddrW-1:0] paddr,
  input  wire logic [lmsd_pkg::PdataW-1:0] pwdata,
  output logic      [lmsd_pkg::PdataW-1:0] prdata,
  output logic                             pready,
  output lmsd_pkg::mode_t                  mode_o
);

  logic [7:0] bright_q, bright_d;
  logic [7:0] min_q, min_d;
  logic [7:0] max_q, max_d;
  logic       wr;
  logic       hit;
  logic       full_on_d;
  logic       stopped_d;
  logic       full_on_q;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  always_comb begin
    bright_d = bright_q;
    min_d    = min_q;
    max_d    = max_q;
    hit      = 1'b0;
    prdata   = '0;
    unique case (idx)
      lmsd_pkg::RegBrightness: begin
        prdata = {24'd0, bright_q};
        if (wr) begin
          bright_d = pwdata[7:0];
          hit      = 1'b1;
        end
      end
      lmsd_pkg::RegMinLevel: begin
        prdata = {24'd0, min_q};
        if (wr) begin
          min_d = pwdata[7:0];
          hit   = 1'b1;
        end
      end
      lmsd_pkg::RegMaxLevel: begin
        prdata = {24'd0, max_q};
        if (wr) begin
          max_d = pwdata[7:0];
          hit   = 1'b1;
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  // Mode after the write decides what the write does to the panel.
  assign full_on_d = bright_d >= max_d;
  assign stopped_d = !full_on_d && (bright_d <= min_d);
  assign full_on_q = bright_q >= max_q;

  always_comb begin
    mode_o.stopped = !full_on_q && (bright_q <= min_q);
    mode_o.dimming = !full_on_q && !(bright_q <= min_q);
    mode_o.level   = lmsd_pkg::GammaLut[bright_q];
    mode_o.set_on  = hit && full_on_d;
    mode_o.set_off = hit && stopped_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= lmsd_pkg::BrightnessRst;
      min_q    <= lmsd_pkg::MinLevelRst;
      max_q    <= lmsd_pkg::MaxLevelRst;
    end else begin
      bright_q <= bright_d;
      min_q    <= min_d;
      max_q    <= max_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lmsd_checker.sv -----
// Port-level checks for the LED matrix scan driver result channel.
// Bound to led_matrix_scan_driver_top; depends on lmsd_pkg.
`default_nettype none

module lmsd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic [1:0] rsp_kind,
  input wire logic [5:0] rsp_rgb_data,
  input wire logic       rsp_latch,
  input wire logic       rsp_last
);

  // Hold a stalled result until it is taken.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // Latch only on the closing column of a section shift.
  a_latch_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_latch |-> (rsp_kind == lmsd_pkg::KIND_SHIFT) && rsp_last)
    else $error("latch outside the last shift column");

  // Read and status items are single results without latch.
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (rsp_kind != lmsd_pkg::KIND_SHIFT) |-> rsp_last && !rsp_latch)
    else $error("read or status item not marked last");

  // A read returns one three-bit pixel.
  a_read_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (rsp_kind == lmsd_pkg::KIND_READ) |-> (rsp_rgb_data[5:3] == 3'd0))
    else $error("read data wider than one pixel");

endmodule

bind led_matrix_scan_driver_top lmsd_checker u_lmsd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid    (rsp_o.valid),
  .rsp_ready    (rsp_o.ready),
  .rsp_kind     (rsp_o.kind),
  .rsp_rgb_data (rsp_o.rgb_data),
  .rsp_latch    (rsp_o.latch),
  .rsp_last     (rsp_o.last)
);

`default_nettype wire
